// ===== design/swsd_pkg.sv =====
// Shared constants and types for the sliding-window spread detector.
`default_nettype none
package swsd_pkg;

    // Default sizes
    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 20;

    // Fixed field widths
    localparam int WL_W     = 9;
    localparam int SPREAD_W = 20;
    localparam int POS_W    = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_MAX_SPREAD    = 1'b1;

    // Control handed to every cell of the sample row
    typedef struct packed {
        logic load;   // take a new word: shift the row, copy it into the scan row
        logic shift;  // advance the scan row by one cell toward the head
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/swsd_ifs.sv =====
// Valid/ready stream interfaces for samples and start positions.
`default_nettype none
interface swsd_sample_if #(
    parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swsd_pos_if ();
    logic                        valid;
    logic                        ready;
    logic [swsd_pkg::POS_W-1:0]  start_position;

    modport source (output valid, output start_position, input ready);
    modport sink   (input valid, input start_position, output ready);
endinterface
`default_nettype wire

// ===== design/sliding_window_spread_detector_core.sv =====
// Top level of the sliding-window spread detector.
// Usage:
//   samples   : sink of unsigned sample words (valid/ready).
//   positions : source of start_position words, one per quiet window.
//   APB port  : window_length at 0x0, max_spread at 0x4; write only while idle.
// Each accepted sample is shifted into a row of MAX_WINDOW cells and copied
// into a scan row. The scan row then walks one cell per cycle past a
// max/min unit over the m newest samples, where m is the effective window
// length (1..MAX_WINDOW); samples is ready again in the cycle after the scan
// ends. A result appears on positions in the cycle after the scan ends and
// sits in an output register, so a new sample is taken while it waits. If
// the receiver still holds off the previous word when the next quiet scan
// ends, the scan end waits until the output register is free.
// Reset clears the sample count, the control state and the output valid,
// and sets window_length to 1 and max_spread to 0. Stale row contents are
// never used: a window is checked only once m samples have arrived.
`default_nettype none
module sliding_window_spread_detector_core #(
    parameter int MAX_WINDOW  = swsd_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    swsd_sample_if.sink                       samples,
    swsd_pos_if.source                        positions,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [swsd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire [swsd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [swsd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import swsd_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int TAP   = (MAX_WINDOW > 1) ? 1 : 0;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Configuration registers
    logic [WL_W-1:0]     wl_reg;
    logic [SPREAD_W-1:0] spread_reg;

    // Control and accumulator state
    logic                   state_reg, state_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [POS_W-1:0]       count_reg, count_next;
    logic                   ok_reg, ok_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [SAMPLE_BITS-1:0] hi_reg, hi_next;
    logic [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic                   out_valid_reg, out_valid_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;

    logic                   accept;
    logic                   cfg_write;
    logic                   reg_idx;
    logic [LEN_W-1:0]       eff_len;
    logic [SAMPLE_BITS-1:0] new_sample;
    logic [SAMPLE_BITS-1:0] probe;
    logic [SAMPLE_BITS-1:0] spread;
    logic                   quiet;
    logic                   out_busy;
    cell_ctrl_t             ctrl;

    logic [SAMPLE_BITS-1:0] cell_sample [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] cell_scan   [MAX_WINDOW];

    // APB register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_WINDOW_LENGTH: prdata = CFG_DATA_W'(wl_reg);
            REG_MAX_SPREAD:    prdata = CFG_DATA_W'(spread_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg     <= WL_W'(1);
            spread_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_WINDOW_LENGTH: wl_reg     <= pwdata[WL_W-1:0];
                REG_MAX_SPREAD:    spread_reg <= pwdata[SPREAD_W-1:0];
                default:           ;
            endcase
        end
    end

    // Clamp the window length to 1..MAX_WINDOW
    always_comb
    begin
        if (wl_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(wl_reg) > 32'(MAX_WINDOW))
            eff_len = LEN_W'(MAX_WINDOW);
        else
            eff_len = LEN_W'(wl_reg);
    end

    // Row of sample cells; the head takes the new word, the tail scans in zero
    assign new_sample = SAMPLE_BITS'(samples.sample);
    assign ctrl       = '{load: accept, shift: (state_reg == ST_SCAN) && (rem_reg != '0)};

    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++)
        begin : g_cell
            logic [SAMPLE_BITS-1:0] left_w;
            logic [SAMPLE_BITS-1:0] right_w;
            if (k == 0)
            begin : g_head
                assign left_w = new_sample;
            end
            else
            begin : g_body
                assign left_w = cell_sample[k-1];
            end
            if (k == MAX_WINDOW - 1)
            begin : g_tail
                assign right_w = '0;
            end
            else
            begin : g_inner
                assign right_w = cell_scan[k+1];
            end
            swsd_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .left_sample (left_w),
                .right_scan  (right_w),
                .sample_q    (cell_sample[k]),
                .scan_q      (cell_scan[k])
            );
        end
    endgenerate

    assign probe    = cell_scan[TAP];
    assign spread   = hi_reg - lo_reg;
    assign quiet    = ok_reg && (32'(spread) <= 32'(spread_reg));
    assign out_busy = out_valid_reg && !positions.ready;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;

    // Sequencer: load on accept, scan m - 1 cells, then post the result if the window is quiet
    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        pos_next       = pos_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_valid_next = out_valid_reg && !positions.ready;
        out_pos_next   = out_pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg != {POS_W{1'b1}})
                        count_next = count_reg + POS_W'(1);
                    len_next   = eff_len;
                    rem_next   = eff_len - LEN_W'(1);
                    ok_next    = count_next >= POS_W'(eff_len);
                    pos_next   = count_next - POS_W'(eff_len) + POS_W'(1);
                    hi_next    = new_sample;
                    lo_next    = new_sample;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rem_reg != '0)
                begin
                    if (probe > hi_reg)
                        hi_next = probe;
                    if (probe < lo_reg)
                        lo_next = probe;
                    rem_next = rem_reg - LEN_W'(1);
                end
                else if (!(quiet && out_busy))
                begin
                    if (quiet)
                    begin
                        out_valid_next = 1'b1;
                        out_pos_next   = pos_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            len_reg       <= LEN_W'(1);
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        out_pos_reg <= out_pos_next;
    end

    assign positions.valid          = out_valid_reg;
    assign positions.start_position = out_pos_reg;

    // Checks
    a_rem_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rem_reg < len_reg))
        else $error("scan count beyond window length");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted word did not start a scan");

    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SCAN && rem_reg == '0))
        else $error("result posted outside scan end");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (count_reg != '0))
        else $error("sample count zero after accept");

endmodule
`default_nettype wire

// ===== design/swsd_cell.sv =====
// One cell of the sample row: a stored sample and a scan copy.
`default_nettype none
module swsd_cell #(
    parameter int SAMPLE_BITS = swsd_pkg::SAMPLE_BITS_DEF
) (
    input  wire                       clk,
    input  wire swsd_pkg::cell_ctrl_t ctrl,
    input  wire [SAMPLE_BITS-1:0]     left_sample,
    input  wire [SAMPLE_BITS-1:0]     right_scan,
    output logic [SAMPLE_BITS-1:0]    sample_q,
    output logic [SAMPLE_BITS-1:0]    scan_q
);
    import swsd_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] scan_reg;

    // Shift the row on a new word; otherwise walk the scan copy toward the head
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sample_reg <= left_sample;
            scan_reg   <= left_sample;
        end
        else if (ctrl.shift)
        begin
            scan_reg <= right_scan;
        end
    end

    assign sample_q = sample_reg;
    assign scan_q   = scan_reg;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sliding-window spread detector core.
module tb_top;
    import swsd_pkg::*;

    localparam int DEPTH       = MAX_WINDOW_DEF;
    localparam int SBITS       = SAMPLE_BITS_DEF;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    swsd_sample_if sample_ch ();
    swsd_pos_if    pos_ch ();

    sliding_window_spread_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .positions (pos_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Mirror of the detector: recent samples, running count, registers
    logic [SBITS-1:0]    window_ring [DEPTH];
    int unsigned         ring_head;
    logic [POS_W-1:0]    samples_seen;
    logic [WL_W-1:0]     cfg_window_length;
    logic [SPREAD_W-1:0] cfg_max_spread;

    logic [POS_W-1:0]    expected_positions [$];
    logic [SBITS-1:0]    pending_samples [$];
    logic [SBITS-1:0]    quiet_base;

    int          errors        = 0;
    int          quiet_cycles  = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;
    int unsigned send_gap      = 0;
    bit          sender_gaps   = 1'b0;
    bit          receiver_gaps = 1'b0;
    logic        sample_taken  = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Window length in force: zero acts as one, clip at the store depth
    function automatic int unsigned window_span();
        int unsigned m;
        m = cfg_window_length;
        if (m == 0)
            m = 1;
        if (m > DEPTH)
            m = DEPTH;
        return m;
    endfunction

    // Queue one word for the driver
    function automatic void add_sample(input logic [SBITS-1:0] x);
        pending_samples.insert(pending_samples.size(), x);
    endfunction

    // Store the word, then queue the window start if the window is quiet
    function automatic void predict_quiet_window(input logic [SBITS-1:0] x);
        int unsigned      m;
        int unsigned      slot;
        logic [SBITS-1:0] hi;
        logic [SBITS-1:0] lo;
        logic [SBITS-1:0] v;
        m = window_span();
        slot = ring_head;
        window_ring[slot] = x;
        ring_head = (slot + 1) % DEPTH;
        if (samples_seen != '1)
            samples_seen++;
        if (samples_seen < m)
            return;
        hi = x;
        lo = x;
        for (int unsigned k = 1; k < m; k++)
        begin
            v = window_ring[(slot + DEPTH - k) % DEPTH];
            if (v > hi)
                hi = v;
            if (v < lo)
                lo = v;
        end
        if (hi - lo <= cfg_max_spread)
            expected_positions.insert(expected_positions.size(),
                                      samples_seen - POS_W'(m) + POS_W'(1));
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int unsigned draw_gap(input bit enabled);
        int unsigned roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Quiet runs around a base, loose runs, rare spikes and jumps of the base
    function automatic logic [SBITS-1:0] next_sample(input int unsigned spike_pct);
        int unsigned    roll;
        logic [SBITS:0] span;
        logic [SBITS:0] top;
        roll = $urandom_range(0, 99);
        if (roll < spike_pct)
            return SBITS'($urandom);
        top = {1'b0, {SBITS{1'b1}}};
        span = (roll >= 90) ? {cfg_max_spread, 1'b1} : {1'b0, cfg_max_spread};
        if (span > top)
            span = top;
        if (roll >= 96 || {1'b0, quiet_base} + span > top)
            quiet_base = SBITS'($urandom_range(0, top - span));
        return quiet_base + SBITS'($urandom_range(0, span));
    endfunction

    // Drive one APB transfer: setup cycle, then access until pready
    task automatic apb_access(input bit is_write, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write a register, update the mirror, read it back
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] readback;
        logic [CFG_DATA_W-1:0] stored;
        addr = CFG_ADDR_W'({idx, 2'b00});
        apb_access(1'b1, addr, value, readback);
        if (idx == REG_WINDOW_LENGTH)
        begin
            cfg_window_length = value[WL_W-1:0];
            stored = CFG_DATA_W'(cfg_window_length);
        end
        else
        begin
            cfg_max_spread = value[SPREAD_W-1:0];
            stored = CFG_DATA_W'(cfg_max_spread);
        end
        apb_access(1'b0, addr, '0, readback);
        if (readback !== stored)
        begin
            $display("%0t: register %0d readback: expected %0h, actual %0h",
                     $time, idx, stored, readback);
            errors++;
        end
    endtask

    // Wait until every word is in and out, then let a last scan finish
    task automatic settle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || sample_ch.valid ||
               expected_positions.size() != 0);
        repeat (window_span() + 8) @(posedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] spread_word,
                             input int count, input bit send_gappy, input bit recv_gappy);
        int unsigned spike_pct;
        settle();
        write_reg(REG_WINDOW_LENGTH, len_word);
        write_reg(REG_MAX_SPREAD, spread_word);
        sender_gaps   = send_gappy;
        receiver_gaps = recv_gappy;
        spike_pct = (window_span() > 32) ? 1 : 5;
        repeat (count) add_sample(next_sample(spike_pct));
    endtask

    // Check each result word against the oldest expectation, then predict
    always @(posedge clk)
    begin
        logic [POS_W-1:0] want;
        if (rst_n)
        begin
            if (pos_ch.valid && pos_ch.ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: start_position: expected none, actual %0d",
                             $time, pos_ch.start_position);
                    errors++;
                end
                else
                begin
                    want = expected_positions[0];
                    expected_positions.delete(0);
                    if (pos_ch.start_position !== want)
                    begin
                        $display("%0t: start_position: expected %0d, actual %0d",
                                 $time, want, pos_ch.start_position);
                        errors++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                predict_quiet_window(sample_ch.sample);
        end
    end

    // Flag accepted samples for the driver; end the run if nothing moves
    always @(posedge clk)
    begin
        sample_taken <= sample_ch.valid && sample_ch.ready;
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (pos_ch.valid && pos_ch.ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Sample driver: hold the word until taken, then gap or advance
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || sample_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_ch.valid  <= 1'b1;
                sample_ch.sample <= pending_samples[0];
                pending_samples.delete(0);
                send_gap <= draw_gap(sender_gaps);
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Position receiver: random stalls, plus a long hold on request
    always @(negedge clk)
    begin
        int unsigned n;
        if (!rst_n)
            pos_ch.ready <= 1'b0;
        else
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pos_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pos_ch.ready <= 1'b0;
            end
            else
            begin
                n = draw_gap(receiver_gaps);
                pos_ch.ready <= (n == 0);
                if (n > 0)
                    stall_left = n - 1;
            end
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] len_word;
        logic [CFG_DATA_W-1:0] spread_word;
        int unsigned           roll;

        rst_n            = 1'b0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        pos_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        ring_head         = 0;
        samples_seen      = '0;
        cfg_window_length = WL_W'(1);
        cfg_max_spread    = '0;
        quiet_base        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: every sample is its own quiet window
        add_sample(20'h00000);
        add_sample(20'hFFFFF);
        add_sample(20'h55555);
        add_sample(20'hAAAAA);
        add_sample(20'h00001);

        // Short windows with zero spread: flat runs pass, a spike breaks them
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd3);
        write_reg(REG_MAX_SPREAD, 32'd0);
        add_sample(20'd7);
        add_sample(20'd7);
        add_sample(20'd7);
        add_sample(20'hFFFFF);
        add_sample(20'd7);
        add_sample(20'd7);
        add_sample(20'd7);
        add_sample(20'd7);

        // Zero length acts as one; widest spread accepts anything
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd0);
        write_reg(REG_MAX_SPREAD, 32'h000FFFFF);
        add_sample(20'h00000);
        add_sample(20'hFFFFF);
        add_sample(20'h12345);

        // Pairs against a spread of one
        settle();
        write_reg(REG_WINDOW_LENGTH, 32'd2);
        write_reg(REG_MAX_SPREAD, 32'd1);
        add_sample(20'd10);
        add_sample(20'd11);
        add_sample(20'd12);
        add_sample(20'd14);
        add_sample(20'h80000);
        add_sample(20'h80001);

        run_phase(32'd4, 32'd16, 80, 1'b1, 1'b1);

        // Hold the receiver off while samples keep coming: block fills and stalls
        run_phase(32'd16, 32'd100, 80, 1'b0, 1'b0);
        hold_requests++;

        run_phase(32'd1, 32'd0, 40, 1'b1, 1'b1);
        run_phase(32'd256, 32'h000FFFFF, 30, 1'b0, 1'b1);
        run_phase({23'($urandom_range(0, 32'h7FFFFF)), 9'd511}, 32'd50, 30, 1'b1, 1'b0);
        run_phase(32'd0, 32'd5, 60, 1'b1, 1'b1);

        // Random settings, stray upper bits in the written data
        repeat (8)
        begin
            roll = $urandom_range(0, 99);
            len_word = (roll < 80) ? $urandom_range(1, 32) : $urandom_range(33, 300);
            len_word = ($urandom & ~32'h1FF) | len_word;
            case ($urandom_range(0, 3))
                0: spread_word = 32'd0;
                1: spread_word = $urandom_range(1, 64);
                2: spread_word = $urandom_range(0, 32'hFFFFF);
                default: spread_word = 32'hFFFFF;
            endcase
            spread_word = ($urandom & ~32'hFFFFF) | spread_word;
            run_phase(len_word, spread_word, 40, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 3) != 0);
        end

        settle();
        if (expected_positions.size() != 0)
        begin
            $display("%0t: %0d start_position words never arrived",
                     $time, expected_positions.size());
            errors++;
        end
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
